// ----- sv/i2cts_pkg.sv -----
`default_nettype none

package i2cts_pkg;

	typedef enum logic [11:0] {
		PH_IDLE    = 12'b0000_0000_0001,
		PH_W_ADDR  = 12'b0000_0000_0010,
		PH_W_CMD   = 12'b0000_0000_0100,
		PH_W_DATA  = 12'b0000_0000_1000,
		PH_W_STOP  = 12'b0000_0001_0000,
		PH_DONE    = 12'b0000_0010_0000,
		PH_R_START = 12'b0000_0100_0000,
		PH_R_ADDR  = 12'b0000_1000_0000,
		PH_R_RECEN = 12'b0001_0000_0000,
		PH_R_STORE = 12'b0010_0000_0000,
		PH_R_REEN  = 12'b0100_0000_0000,
		PH_R_STOP  = 12'b1000_0000_0000
	} phase_t;

	localparam logic [1:0] MODE_LD_CMD = 2'd0;
	localparam logic [1:0] MODE_LD_TX  = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;
	localparam logic [1:0] MODE_EVENT  = 2'd3;

	localparam logic [1:0] KIND_WR    = 2'd0;
	localparam logic [1:0] KIND_WR_RD = 2'd1;
	localparam logic [1:0] KIND_RD    = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_SEND  = 3'd2;
	localparam logic [2:0] CMD_RCEN  = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;
	localparam logic [2:0] CMD_STOP  = 3'd5;

	localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
	localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

endpackage

`default_nettype wire

// ----- sv/i2cts_store.sv -----
`default_nettype none

module i2cts_store #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// forward a write that hits the prefetched entry
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ----- sv/i2c_master_transaction_sequencer_unit.sv -----
// I2C master transaction sequencer, sitting above a byte-level bus engine.
// Input channel (in_valid / in_stall): one request per item. A request loads a
// command byte, loads a transmit byte, starts a transaction, or reports a
// finished bus operation with its ACK status and received byte.
// Output channel (out_valid / out_stall): exactly one result per request,
// giving the next bus command, any received byte, done/ok and busy status.
// A request is registered in the input register on acceptance, and its result is
// registered in the output register once that register is free to take it.
// Throughput: one request per cycle while out_stall is low; the step logic is a
// single state transition and the store reads are prefetched at the next byte
// position. A stalled result holds the output register; one request more is
// taken into the input register, then in_stall rises until the result is taken.
// Reset (arst_n low) empties both registers and returns the sequencer to idle.
// The command and transmit stores are not cleared; read entries only after
// loading them.
`default_nettype none

module i2c_master_transaction_sequencer_unit
	import i2cts_pkg::*;
#(
	parameter int CMD_DEPTH = 16,
	parameter int DATA_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [1:0] xfer_kind,
	input  wire logic [5:0] load_index,
	input  wire logic [7:0] load_byte,
	input  wire logic [7:0] dev_addr,
	input  wire logic [4:0] cmd_length,
	input  wire logic [6:0] data_length,
	input  wire logic       bus_ok,
	input  wire logic       ack_status,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            accepted,
	output logic      [2:0] bus_cmd,
	output logic      [7:0] tx_byte,
	output logic            ack_bit,
	output logic            rx_valid,
	output logic      [5:0] rx_index,
	output logic      [7:0] rx_data,
	output logic            done_res,
	output logic            done_ok,
	output logic            busy_res
);

	localparam int CMD_AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int DATA_AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [1:0] kind_s1;
	logic [5:0] li_s1;
	logic [7:0] lb_s1;
	logic [7:0] addr_s1;
	logic [4:0] clen_s1;
	logic [6:0] dlen_s1;
	logic       bok_s1;
	logic       nack_s1;
	logic [7:0] rxb_s1;

	logic       valid_s2;
	logic       acc_s2;
	logic [2:0] cmd_s2;
	logic [7:0] tx_s2;
	logic       ackb_s2;
	logic       rxv_s2;
	logic [5:0] rxi_s2;
	logic [7:0] rxd_s2;
	logic       done_s2;
	logic       ok_s2;
	logic       busy_s2;

	phase_t     phase_q, phase_d;
	logic       busy_q, busy_d;
	logic [6:0] bp_q, bp_d, bp_inc;
	logic [7:0] taddr_q, taddr_d;
	logic [4:0] ccnt_q, ccnt_d, clen_sat;
	logic [6:0] txc_q, txc_d, rxc_q, rxc_d, dlen_sat;

	logic       r_acc, r_ackb, r_rxv, r_done, r_ok;
	logic [2:0] r_cmd;
	logic [7:0] r_tx, r_rxd;
	logic [5:0] r_rxi;

	logic       cmd_we, tx_we;
	logic [7:0] cmd_rd, tx_rd;
	logic       free, adv, take;

	assign free     = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			kind_s1 <= xfer_kind;
			li_s1   <= load_index;
			lb_s1   <= load_byte;
			addr_s1 <= dev_addr;
			clen_s1 <= cmd_length;
			dlen_s1 <= data_length;
			bok_s1  <= bus_ok;
			nack_s1 <= ack_status;
			rxb_s1  <= rx_byte;
		end
	end

	assign clen_sat = (32'(clen_s1) > CMD_DEPTH) ? 5'(CMD_DEPTH) : clen_s1;
	assign dlen_sat = (32'(dlen_s1) > DATA_DEPTH) ? 7'(DATA_DEPTH) : dlen_s1;
	assign bp_inc   = bp_q + 7'd1;

	always_comb begin
		phase_d = phase_q;
		busy_d  = busy_q;
		bp_d    = bp_q;
		taddr_d = taddr_q;
		ccnt_d  = ccnt_q;
		txc_d   = txc_q;
		rxc_d   = rxc_q;
		r_acc   = 1'b0;
		r_cmd   = CMD_NONE;
		r_tx    = '0;
		r_ackb  = 1'b0;
		r_rxv   = 1'b0;
		r_rxi   = '0;
		r_rxd   = '0;
		r_done  = 1'b0;
		r_ok    = 1'b0;
		cmd_we  = 1'b0;
		tx_we   = 1'b0;
		if (adv) begin
			unique case (mode_s1)
				MODE_LD_CMD: cmd_we = (32'(li_s1) < CMD_DEPTH);
				MODE_LD_TX:  tx_we = (32'(li_s1) < DATA_DEPTH);
				MODE_START: begin
					if (!busy_q && bok_s1 && (kind_s1 != KIND_RSVD)) begin
						taddr_d = addr_s1;
						ccnt_d  = (kind_s1 == KIND_RD) ? 5'd0 : clen_sat;
						txc_d   = (kind_s1 == KIND_WR) ? dlen_sat : 7'd0;
						rxc_d   = (kind_s1 == KIND_WR) ? 7'd0 : dlen_sat;
						bp_d    = '0;
						busy_d  = 1'b1;
						phase_d = (kind_s1 == KIND_RD) ? PH_R_ADDR : PH_W_ADDR;
						r_acc   = 1'b1;
						r_cmd   = CMD_START;
					end
				end
				MODE_EVENT: begin
					if (busy_q) begin
						unique case (phase_q)
							PH_W_ADDR: begin
								r_cmd   = CMD_SEND;
								r_tx    = taddr_q & ADDR_WR_MASK;
								phase_d = PH_W_CMD;
							end
							PH_W_CMD: begin
								if (nack_s1) begin
									r_cmd   = CMD_STOP;
									r_done  = 1'b1;
									phase_d = PH_IDLE;
									busy_d  = 1'b0;
								end else if (ccnt_q == '0) begin
									r_cmd   = CMD_STOP;
									phase_d = PH_DONE;
								end else begin
									r_cmd = CMD_SEND;
									r_tx  = cmd_rd;
									bp_d  = bp_inc;
									if (bp_inc >= {2'b00, ccnt_q}) begin
										bp_d    = '0;
										phase_d = (rxc_q != '0) ? PH_R_START : PH_W_DATA;
									end
								end
							end
							PH_W_DATA: begin
								if (nack_s1) begin
									r_cmd   = CMD_STOP;
									r_done  = 1'b1;
									phase_d = PH_IDLE;
									busy_d  = 1'b0;
								end else if (txc_q == '0) begin
									r_cmd   = CMD_STOP;
									phase_d = PH_DONE;
								end else begin
									r_cmd = CMD_SEND;
									r_tx  = tx_rd;
									bp_d  = bp_inc;
									if (bp_inc >= txc_q) begin
										phase_d = PH_W_STOP;
									end
								end
							end
							PH_W_STOP: begin
								r_cmd = CMD_STOP;
								if (nack_s1) begin
									r_done  = 1'b1;
									phase_d = PH_IDLE;
									busy_d  = 1'b0;
								end else begin
									phase_d = PH_DONE;
								end
							end
							PH_DONE: begin
								r_done  = 1'b1;
								r_ok    = 1'b1;
								phase_d = PH_IDLE;
								busy_d  = 1'b0;
							end
							PH_R_START: begin
								if (nack_s1) begin
									r_cmd   = CMD_STOP;
									r_done  = 1'b1;
									phase_d = PH_IDLE;
									busy_d  = 1'b0;
								end else begin
									bp_d    = '0;
									r_cmd   = CMD_START;
									phase_d = PH_R_ADDR;
								end
							end
							PH_R_ADDR: begin
								r_cmd   = CMD_SEND;
								r_tx    = taddr_q | ADDR_RD_BIT;
								bp_d    = '0;
								phase_d = PH_R_RECEN;
							end
							PH_R_RECEN: begin
								if (nack_s1) begin
									r_cmd   = CMD_STOP;
									r_done  = 1'b1;
									phase_d = PH_IDLE;
									busy_d  = 1'b0;
								end else if (rxc_q == '0) begin
									r_cmd   = CMD_STOP;
									phase_d = PH_DONE;
								end else begin
									r_cmd   = CMD_RCEN;
									phase_d = PH_R_STORE;
								end
							end
							PH_R_STORE: begin
								r_rxv = 1'b1;
								r_rxi = bp_q[5:0];
								r_rxd = rxb_s1;
								bp_d  = bp_inc;
								r_cmd = CMD_ACK;
								if (bp_inc >= rxc_q) begin
									r_ackb  = 1'b1;
									phase_d = PH_R_STOP;
								end else begin
									phase_d = PH_R_REEN;
								end
							end
							PH_R_REEN: begin
								r_cmd   = CMD_RCEN;
								phase_d = PH_R_STORE;
							end
							PH_R_STOP: begin
								r_cmd   = CMD_STOP;
								phase_d = PH_DONE;
							end
							default: begin
								phase_d = PH_IDLE;
								busy_d  = 1'b0;
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			busy_q  <= 1'b0;
			bp_q    <= '0;
			taddr_q <= '0;
			ccnt_q  <= '0;
			txc_q   <= '0;
			rxc_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			busy_q  <= busy_d;
			bp_q    <= bp_d;
			taddr_q <= taddr_d;
			ccnt_q  <= ccnt_d;
			txc_q   <= txc_d;
			rxc_q   <= rxc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2  <= r_acc;
			cmd_s2  <= r_cmd;
			tx_s2   <= r_tx;
			ackb_s2 <= r_ackb;
			rxv_s2  <= r_rxv;
			rxi_s2  <= r_rxi;
			rxd_s2  <= r_rxd;
			done_s2 <= r_done;
			ok_s2   <= r_ok;
			busy_s2 <= busy_d;
		end
	end

	i2cts_store #(
		.DEPTH (CMD_DEPTH),
		.AW    (CMD_AW)
	) u_cmd_store (
		.clk     (clk),
		.wr_en   (cmd_we),
		.wr_addr (CMD_AW'(li_s1)),
		.wr_data (lb_s1),
		.rd_addr (CMD_AW'(bp_d)),
		.rd_data (cmd_rd)
	);

	i2cts_store #(
		.DEPTH (DATA_DEPTH),
		.AW    (DATA_AW)
	) u_tx_store (
		.clk     (clk),
		.wr_en   (tx_we),
		.wr_addr (DATA_AW'(li_s1)),
		.wr_data (lb_s1),
		.rd_addr (DATA_AW'(bp_d)),
		.rd_data (tx_rd)
	);

	assign out_valid = valid_s2;
	assign accepted  = acc_s2;
	assign bus_cmd   = cmd_s2;
	assign tx_byte   = tx_s2;
	assign ack_bit   = ackb_s2;
	assign rx_valid  = rxv_s2;
	assign rx_index  = rxi_s2;
	assign rx_data   = rxd_s2;
	assign done_res  = done_s2;
	assign done_ok   = ok_s2;
	assign busy_res  = busy_s2;

`ifndef SYNTH
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (phase_q != PH_IDLE))
		else $error("busy flag disagrees with sequencer phase");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (bus_cmd == CMD_START && busy_res && !done_res))
		else $error("accepted start without start command or busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("done reported while still busy");

	a_rx_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rx_valid) |-> (bus_cmd == CMD_ACK))
		else $error("received byte delivered without acknowledge");
`endif

endmodule

`default_nettype wire
